### design/bfdt_pkg.sv
`timescale 1ns / 1ps

package bfdt_pkg;

  localparam int unsigned MilliW = 20;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 7;
  localparam int unsigned PosW   = 3;
  localparam int unsigned DigitW = 4;

  localparam logic [ValueW-1:0] OvfLimit = 32'd255999;
  localparam logic [9:0]        MilliScale = 10'd1000;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  localparam logic [PosW-1:0] PosHund  = 3'd0;
  localparam logic [PosW-1:0] PosTens  = 3'd1;
  localparam logic [PosW-1:0] PosUnits = 3'd2;
  localparam logic [PosW-1:0] PosPoint = 3'd3;
  localparam logic [PosW-1:0] PosTenth = 3'd4;
  localparam logic [PosW-1:0] PosHth   = 3'd5;

  localparam logic [CharW-1:0] ChSpace = 7'h20;
  localparam logic [CharW-1:0] ChStar  = 7'h2A;
  localparam logic [CharW-1:0] ChPoint = 7'h2E;
  localparam logic [CharW-1:0] ChZero  = 7'h30;
  localparam logic [CharW-1:0] ChNine  = 7'h39;

  typedef struct packed {
    logic              ovf;
    logic [MilliW-1:0] milli;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [MilliW-1:0] digit_weight(input logic [PosW-1:0] pos);
    logic [MilliW-1:0] w;
    case (pos)
      PosHund:  w = 20'd100000;
      PosTens:  w = 20'd10000;
      PosUnits: w = 20'd1000;
      PosTenth: w = 20'd100;
      PosHth:   w = 20'd10;
      default:  w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [MilliW-1:0] weight_mult(input logic [PosW-1:0] pos,
                                                   input logic [DigitW-1:0] k);
    logic [MilliW+DigitW-1:0] p;
    p = {{DigitW{1'b0}}, digit_weight(pos)} * {{MilliW{1'b0}}, k};
    return p[MilliW-1:0];
  endfunction

endpackage

### design/bfdt_front.sv
`timescale 1ns / 1ps

module bfdt_front import bfdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] fixed_value_i,
  output logic              push_o,
  input  logic              push_ready_i,
  output item_t             push_item_o
);

  logic        valid_q, valid_d;
  item_t       item_q, item_d;
  logic        accept;
  logic [27:0] prod;

  assign push_o      = valid_q;
  assign push_item_o = item_q;
  assign in_stall_o  = valid_q && !push_ready_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    prod         = {10'd0, fixed_value_i[17:0]} * {18'd0, MilliScale};
    item_d.ovf   = fixed_value_i > OvfLimit;
    item_d.milli = prod[27:8];
    valid_d      = accept || (valid_q && !push_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

### design/bfdt_queue.sv
`timescale 1ns / 1ps

module bfdt_queue import bfdt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  output logic    push_ready_o,
  input  item_t   push_item_i,
  output q_head_t head_o,
  input  logic    pop_i
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             do_push;

  assign push_ready_o = count_q != (QPtrW+1)'(QDepth);
  assign do_push      = push_i && push_ready_o;
  assign head_o.valid = count_q != '0;
  assign head_o.item  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_next(input logic [QPtrW-1:0] p);
    return (p == QPtrW'(QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && pop_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### design/bfdt_back.sv
`timescale 1ns / 1ps

module bfdt_back import bfdt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_head_t          head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CharW-1:0] char_code_o,
  output logic             last_char_o
);

  logic [PosW-1:0]   pos_q, pos_d;
  logic [MilliW-1:0] rem_q, rem_d;
  logic              ovf_q, lead_q;
  logic              out_valid_q;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q;

  logic [MilliW-1:0] cur;
  logic              cur_ovf, have, fire, load_en;
  logic [DigitW-1:0] digit;
  logic [CharW-1:0]  digit_char;

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

  always_comb begin
    cur     = (pos_q == PosHund) ? head_i.item.milli : rem_q;
    cur_ovf = (pos_q == PosHund) ? head_i.item.ovf : ovf_q;
    have    = (pos_q == PosHund) ? head_i.valid : 1'b1;
    load_en = !out_valid_q || !out_stall_i;
    fire    = have && load_en;
    pop_o   = fire && (pos_q == PosHund);

    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (cur >= weight_mult(pos_q, DigitW'(k))) begin
        digit = DigitW'(k);
      end
    end
    rem_d      = cur - weight_mult(pos_q, digit);
    digit_char = ChZero + {3'd0, digit};
    pos_d      = (pos_q == PosHth) ? PosHund : pos_q + 1'b1;

    case (pos_q)
      PosHund:  char_d = (digit == '0) ? ChSpace : digit_char;
      PosTens:  char_d = (lead_q && digit == '0) ? ChSpace : digit_char;
      PosPoint: char_d = ChPoint;
      default:  char_d = digit_char;
    endcase
    if (cur_ovf && pos_q != PosPoint) begin
      char_d = ChStar;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosHund;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        pos_q <= pos_d;
      end
      if (load_en) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rem_q  <= rem_d;
      ovf_q  <= cur_ovf;
      char_q <= char_d;
      last_q <= pos_q == PosHth;
      if (pos_q == PosHund) begin
        lead_q <= digit == '0;
      end
    end
  end

endmodule

### design/binary_fixed_to_decimal_text.sv
`timescale 1ns / 1ps
// Channel  Valid        Stall        Payload
// input    in_valid_i   in_stall_o   fixed_value_i[31:0]
// output   out_valid_o  out_stall_i  char_code_o[6:0], last_char_o
//
// Each request gives six characters, one per cycle while out_stall_i is low; the
// rate is set by the single character output register of the back end.
// The first character passes through the front register, the queue and the
// output register. Asynchronous active-low reset clears all control state. The
// front and back stall apart through a two-entry queue.

module binary_fixed_to_decimal_text import bfdt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] fixed_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CharW-1:0]  char_code_o,
  output logic              last_char_o
);

  logic    push, push_ready, pop;
  item_t   push_item;
  q_head_t head;

  bfdt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .fixed_value_i(fixed_value_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  bfdt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .push_item_i (push_item),
    .head_o      (head),
    .pop_i       (pop)
  );

  bfdt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .char_code_o(char_code_o),
    .last_char_o(last_char_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head.valid && !head.item.ovf |-> head.item.milli <= 20'd999996)
    else $error("scaled value out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_code_o >= ChZero && char_code_o <= ChNine) ||
                    char_code_o == ChSpace || char_code_o == ChPoint ||
                    char_code_o == ChStar)
    else $error("illegal character code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_char_o |=> !(out_valid_o && last_char_o))
    else $error("last character repeated");

endmodule
